### hdl/alc_pkg.sv
package alc_pkg;

    localparam int TAG_W  = 64;
    localparam int ALG_W  = 4;
    localparam int HDL_W  = 32;
    localparam int TIME_W = 32;
    localparam int MODE_W = 3;
    localparam int STAT_W = 2;
    localparam int OCNT_W = 7;
    localparam int IDX_W  = 10;   // holds any slot index in the parameter range
    localparam int CNT_W  = 11;   // holds any slot count in the parameter range
    localparam int IN_W   = 136;
    localparam int OUT_W  = 184;

    localparam logic [TIME_W-1:0] DEFAULT_AGE = 32'd3600;

    localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_EXPIRE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FLUSH  = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FND  = 2'd1;
    localparam logic [STAT_W-1:0] ST_ZERO_HDL = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_TOUCH,
        OP_WRITE,
        OP_CLEAR,
        OP_EXPIRE,
        OP_FLUSH
    } t_op;

    // request broadcast to every cell during the scan
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [ALG_W-1:0]  alg;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] lim;
    } t_req;

    // running result handed from cell to cell
    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  found_idx;
        logic [HDL_W-1:0]  found_hdl;
        logic              free_ok;
        logic [IDX_W-1:0]  free_idx;
        logic              old_ok;
        logic [TIME_W-1:0] old_ts;
        logic [IDX_W-1:0]  old_idx;
        logic [HDL_W-1:0]  old_hdl;
        logic [CNT_W-1:0]  exp_cnt;
    } t_scan;

    // update command broadcast to every cell at once
    typedef struct packed {
        t_op               op;
        logic [IDX_W-1:0]  idx;
        logic [TAG_W-1:0]  tag;
        logic [ALG_W-1:0]  alg;
        logic [HDL_W-1:0]  hdl;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] lim;
    } t_cmd;

endpackage

### hdl/alc_cell.sv
module alc_cell #(
    parameter int IDX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  alc_pkg::t_req  i_req,
    input  alc_pkg::t_scan i_scan,
    output alc_pkg::t_scan o_scan,
    input  alc_pkg::t_cmd  i_cmd
);

    localparam logic [alc_pkg::IDX_W-1:0] MY_IDX = alc_pkg::IDX_W'(IDX);

    logic                        r_valid;
    logic [alc_pkg::TAG_W-1:0]   r_tag;
    logic [alc_pkg::ALG_W-1:0]   r_alg;
    logic [alc_pkg::HDL_W-1:0]   r_hdl;
    logic [alc_pkg::TIME_W-1:0]  r_last;
    alc_pkg::t_scan              r_scan;
    alc_pkg::t_scan              n_scan;
    logic                        match;
    logic                        aged_scan;
    logic                        aged_cmd;
    logic                        hit_me;

    assign match     = r_valid && (r_tag == i_req.tag) && (r_alg == i_req.alg);
    assign aged_scan = r_valid && ((i_req.now - r_last) > i_req.lim);
    assign aged_cmd  = r_valid && ((i_cmd.now - r_last) > i_cmd.lim);
    assign hit_me    = (i_cmd.idx == MY_IDX);

    always_comb begin
        n_scan = i_scan;
        if (!i_scan.found && match) begin
            n_scan.found     = 1'b1;
            n_scan.found_idx = MY_IDX;
            n_scan.found_hdl = r_hdl;
        end
        if (!i_scan.free_ok && !r_valid) begin
            n_scan.free_ok  = 1'b1;
            n_scan.free_idx = MY_IDX;
        end
        if (r_valid && (!i_scan.old_ok || (r_last < i_scan.old_ts))) begin
            n_scan.old_ok  = 1'b1;
            n_scan.old_ts  = r_last;
            n_scan.old_idx = MY_IDX;
            n_scan.old_hdl = r_hdl;
        end
        n_scan.exp_cnt = i_scan.exp_cnt + alc_pkg::CNT_W'(aged_scan);
    end

    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                alc_pkg::OP_TOUCH: begin
                    if (hit_me) r_last <= i_cmd.now;
                end
                alc_pkg::OP_WRITE: begin
                    if (hit_me) begin
                        r_valid <= 1'b1;
                        r_tag   <= i_cmd.tag;
                        r_alg   <= i_cmd.alg;
                        r_hdl   <= i_cmd.hdl;
                        r_last  <= i_cmd.now;
                    end
                end
                alc_pkg::OP_CLEAR: begin
                    if (hit_me) r_valid <= 1'b0;
                end
                alc_pkg::OP_EXPIRE: begin
                    if (aged_cmd) r_valid <= 1'b0;
                end
                alc_pkg::OP_FLUSH: begin
                    r_valid <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_scan = r_scan;

endmodule

### hdl/assoc_lru_cache_with_expiry_top.sv
// channel | dir | ports                         | contents
// config  | in  | i_cfg_we, i_cfg_wdata         | max_age register
// request | in  | i_s_tvalid/o_s_tready/i_s_tdata | one request word
// result  | out | o_m_tvalid/i_m_tready/o_m_tdata | one result word per request
//
// each request runs through S_SCAN, where the scan ripples through the row of
// ENTRIES cells one cell per cycle, then S_DECIDE decides and updates the cells
// requests are taken one at a time; a new one is accepted while the last
// result still waits in the output register
// a finished result waits in the decide state while the output register is full
// i_rst_n is synchronous, active low; it empties every slot and clears counters
module assoc_lru_cache_with_expiry_top #(
    parameter int ENTRIES = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [31:0]               i_cfg_wdata,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    // mode[2:0], key_tag[66:3], algorithm[70:67], handle[102:71], now[134:103]
    input  logic [alc_pkg::IN_W-1:0]  i_s_tdata,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    // hit[0], handle_out[32:1], status[34:33], released_valid[35],
    // released_handle[67:36], expired_count[74:68], entry_count[81:75],
    // hit_total[113:82], miss_total[145:114], eviction_total[177:146]
    output logic [alc_pkg::OUT_W-1:0] o_m_tdata
);

    localparam int SCW = $clog2(ENTRIES);
    localparam logic [SCW-1:0] SCAN_LAST = SCW'(ENTRIES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } t_state;

    t_state                        r_state;
    logic [SCW-1:0]                r_cnt;
    logic [31:0]                   r_max_age;
    logic [alc_pkg::MODE_W-1:0]    r_mode;
    logic [alc_pkg::HDL_W-1:0]     r_hdl;
    alc_pkg::t_req                 r_req;
    logic [alc_pkg::CNT_W-1:0]     r_entries;
    logic [31:0]                   r_hits;
    logic [31:0]                   r_misses;
    logic [31:0]                   r_evict;
    logic                          r_out_valid;
    logic [alc_pkg::OUT_W-1:0]     r_out;

    alc_pkg::t_scan                chain [ENTRIES+1];
    alc_pkg::t_cmd                 cmd;
    alc_pkg::t_cmd                 cmd_fire;
    alc_pkg::t_scan                tail;

    logic                          in_fire;
    logic                          out_free;
    logic                          fire;

    // decision results
    logic                          d_hit;
    logic [alc_pkg::HDL_W-1:0]     d_hout;
    logic [alc_pkg::STAT_W-1:0]    d_status;
    logic                          d_relv;
    logic [alc_pkg::HDL_W-1:0]     d_relh;
    logic [alc_pkg::CNT_W-1:0]     d_exp;
    logic [alc_pkg::CNT_W-1:0]     n_entries;
    logic [31:0]                   n_hits;
    logic [31:0]                   n_misses;
    logic [31:0]                   n_evict;
    logic [alc_pkg::CNT_W+6:0]     exp_wide;
    logic [alc_pkg::CNT_W+6:0]     cnt_wide;

    assign o_s_tready = (r_state == S_IDLE);
    assign in_fire    = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign fire       = (r_state == S_DECIDE) && out_free;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    // head of the chain starts empty
    assign chain[0] = '0;
    assign tail     = chain[ENTRIES];

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        alc_cell #(.IDX(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_req  (r_req),
            .i_scan (chain[g]),
            .o_scan (chain[g+1]),
            .i_cmd  (cmd_fire)
        );
    end

    // decide from the scan result at the tail of the chain
    always_comb begin
        cmd       = '0;
        cmd.op    = alc_pkg::OP_NONE;
        cmd.tag   = r_req.tag;
        cmd.alg   = r_req.alg;
        cmd.hdl   = r_hdl;
        cmd.now   = r_req.now;
        cmd.lim   = r_req.lim;
        d_hit     = 1'b0;
        d_hout    = '0;
        d_status  = alc_pkg::ST_OK;
        d_relv    = 1'b0;
        d_relh    = '0;
        d_exp     = '0;
        n_entries = r_entries;
        n_hits    = r_hits;
        n_misses  = r_misses;
        n_evict   = r_evict;
        unique case (r_mode)
            alc_pkg::MODE_LOOKUP: begin
                if (tail.found) begin
                    d_hit   = 1'b1;
                    d_hout  = tail.found_hdl;
                    cmd.op  = alc_pkg::OP_TOUCH;
                    cmd.idx = tail.found_idx;
                    n_hits  = r_hits + 32'd1;
                end else begin
                    n_misses = r_misses + 32'd1;
                end
            end
            alc_pkg::MODE_INSERT: begin
                if (r_hdl == '0) begin
                    d_status = alc_pkg::ST_ZERO_HDL;
                end else if (tail.found) begin
                    // replace in place; release only a changed handle
                    cmd.op  = alc_pkg::OP_WRITE;
                    cmd.idx = tail.found_idx;
                    if (tail.found_hdl != r_hdl) begin
                        d_relv = 1'b1;
                        d_relh = tail.found_hdl;
                    end
                end else if (tail.free_ok) begin
                    cmd.op    = alc_pkg::OP_WRITE;
                    cmd.idx   = tail.free_idx;
                    n_entries = r_entries + alc_pkg::CNT_W'(1);
                end else begin
                    // full table: evict oldest, lowest index on a tie
                    cmd.op  = alc_pkg::OP_WRITE;
                    cmd.idx = tail.old_idx;
                    d_relv  = 1'b1;
                    d_relh  = tail.old_hdl;
                    n_evict = r_evict + 32'd1;
                end
            end
            alc_pkg::MODE_REMOVE: begin
                if (tail.found) begin
                    cmd.op    = alc_pkg::OP_CLEAR;
                    cmd.idx   = tail.found_idx;
                    d_relv    = 1'b1;
                    d_relh    = tail.found_hdl;
                    n_entries = r_entries - alc_pkg::CNT_W'(1);
                end else begin
                    d_status = alc_pkg::ST_NOT_FND;
                end
            end
            alc_pkg::MODE_EXPIRE: begin
                cmd.op    = alc_pkg::OP_EXPIRE;
                d_exp     = tail.exp_cnt;
                n_entries = r_entries - tail.exp_cnt;
            end
            alc_pkg::MODE_FLUSH: begin
                cmd.op    = alc_pkg::OP_FLUSH;
                n_entries = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        cmd_fire = cmd;
        if (!fire) cmd_fire.op = alc_pkg::OP_NONE;
    end

    // counts reported as their low 7 bits
    assign exp_wide = {7'd0, d_exp};
    assign cnt_wide = {7'd0, n_entries};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_max_age   <= alc_pkg::DEFAULT_AGE;
            r_entries   <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_evict     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_max_age <= i_cfg_wdata;
            // output register loads on a decision, empties when taken
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_state   <= S_SCAN;
                        r_cnt     <= '0;
                        r_mode    <= i_s_tdata[2:0];
                        r_req.tag <= i_s_tdata[66:3];
                        r_req.alg <= i_s_tdata[70:67];
                        r_hdl     <= i_s_tdata[102:71];
                        r_req.now <= i_s_tdata[134:103];
                        r_req.lim <= (r_max_age == '0) ? alc_pkg::DEFAULT_AGE : r_max_age;
                    end
                end
                S_SCAN: begin
                    // count the scan until the result reaches the tail
                    r_cnt <= r_cnt + SCW'(1);
                    if (r_cnt == SCAN_LAST) r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (out_free) begin
                        r_state     <= S_IDLE;
                        r_entries   <= n_entries;
                        r_hits      <= n_hits;
                        r_misses    <= n_misses;
                        r_evict     <= n_evict;
                        r_out       <= {6'd0, n_evict, n_misses, n_hits,
                                        cnt_wide[6:0], exp_wide[6:0], d_relh, d_relv,
                                        d_status, d_hout, d_hit};
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // a request is never taken twice in a row
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_s_tready)
        else $error("request accepted while busy");

    // slot count never exceeds the table size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_entries <= alc_pkg::CNT_W'(ENTRIES))
        else $error("entry count out of range");

    // a fresh result only follows a decide cycle
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == S_DECIDE))
        else $error("result without decision");

    // the scan does not end before the counter reaches the last cell
    a_scan_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_cnt != SCAN_LAST) |=> r_state == S_SCAN)
        else $error("scan cut short");

endmodule
